### sv/isort_pkg.sv
// Shared types and constants for the insertion sorter.
`default_nettype none

package isort_pkg;

    localparam int MAX_ITEMS   = 64;
    localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic signed [31:0] item_value;
        logic               item_last;
    } item_t;

    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               sorted_last;
        logic               dropped_any;
    } result_t;

    // What the back end has to do with one queued beat
    typedef enum logic [1:0] {
        OP_INSERT      = 2'd0,
        OP_INSERT_EMIT = 2'd1,
        OP_DROP        = 2'd2,
        OP_DROP_EMIT   = 2'd3
    } op_t;

    typedef struct packed {
        op_t                op;
        logic signed [31:0] value;
    } qentry_t;

endpackage : isort_pkg

`default_nettype wire

### sv/isort_front.sv
// Front end: takes input beats, tracks list fill and tags each beat with an op.
`default_nettype none

module isort_front
    import isort_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire item_t   item,
    input  wire logic    queue_full,
    output logic         busy,
    output logic         push,
    output qentry_t      push_data
);

    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             room;

    assign busy = queue_full;
    assign push = start && !queue_full;
    assign room = (fill_reg < CNT_W'(MAX_ITEMS));

    always_comb
    begin
        push_data.value = item.item_value;
        unique case ({room, item.item_last})
            2'b10:   push_data.op = OP_INSERT;
            2'b11:   push_data.op = OP_INSERT_EMIT;
            2'b00:   push_data.op = OP_DROP;
            default: push_data.op = OP_DROP_EMIT;
        endcase
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (push)
        begin
            if (item.item_last)
                fill_next = '0;
            else if (room)
                fill_next = fill_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else
            fill_reg <= fill_next;
    end

endmodule : isort_front

`default_nettype wire

### sv/isort_queue.sv
// Short FIFO between front and back ends.
`default_nettype none

module isort_queue
    import isort_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire qentry_t push_data,
    input  wire logic    pop,
    output logic         full,
    output logic         not_empty,
    output qentry_t      head
);

    qentry_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QLVL_W-1:0] level_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = (level_reg == QLVL_W'(QUEUE_DEPTH));
    assign not_empty = (level_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + QPTR_W'(1);
            if (do_push && !do_pop)
                level_reg <= level_reg + QLVL_W'(1);
            else if (do_pop && !do_push)
                level_reg <= level_reg - QLVL_W'(1);
        end
    end

endmodule : isort_queue

`default_nettype wire

### sv/isort_back.sv
// Back end: systolic insertion row and shift-out of the sorted list.
`default_nettype none

module isort_back
    import isort_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    q_valid,
    input  wire qentry_t q_head,
    output logic         pop,
    output logic         result_valid,
    output result_t      result
);

    typedef enum logic [1:0] {
        ST_RUN  = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               overflow_reg;
    logic               overflow_next;
    logic signed [31:0] cell_reg  [MAX_ITEMS];
    logic signed [31:0] cell_next [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] gt;
    logic               do_insert;
    logic               do_shift;

    assign pop       = q_valid && (state_reg == ST_RUN);
    assign do_insert = pop && (q_head.op == OP_INSERT || q_head.op == OP_INSERT_EMIT);
    assign do_shift  = (state_reg == ST_EMIT);

    // Each cell: empty slots count as greater, so the new value lands before the first greater value
    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        assign gt[i] = (CNT_W'(i) >= count_reg) || (cell_reg[i] > q_head.value);

        always_comb
        begin
            cell_next[i] = cell_reg[i];
            if (do_shift)
            begin
                if (i < MAX_ITEMS - 1)
                    cell_next[i] = cell_reg[(i < MAX_ITEMS - 1) ? i + 1 : i];
            end
            else if (do_insert && gt[i])
            begin
                if (i == 0)
                    cell_next[i] = q_head.value;
                else
                    cell_next[i] = gt[(i > 0) ? i - 1 : 0] ? cell_reg[(i > 0) ? i - 1 : 0]
                                                           : q_head.value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_ITEMS; i++)
            cell_reg[i] <= cell_next[i];
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        overflow_next = overflow_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (pop)
                begin
                    unique case (q_head.op)
                        OP_INSERT:
                            count_next = count_reg + CNT_W'(1);
                        OP_INSERT_EMIT:
                        begin
                            count_next = count_reg + CNT_W'(1);
                            state_next = ST_EMIT;
                        end
                        OP_DROP:
                            overflow_next = 1'b1;
                        default:
                        begin
                            overflow_next = 1'b1;
                            state_next    = ST_EMIT;
                        end
                    endcase
                end
            end
            default:
            begin
                count_next = count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    state_next    = ST_RUN;
                    overflow_next = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_RUN;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
        end
    end

    assign result_valid        = do_shift;
    assign result.sorted_value = cell_reg[0];
    assign result.sorted_last  = (count_reg == CNT_W'(1));
    assign result.dropped_any  = overflow_reg;

endmodule : isort_back

`default_nettype wire

### sv/insertion_sorter.sv
// Top level of the insertion sorter: front end, beat queue and insertion row.
//
// Sorts one list of signed 32-bit values at a time, ascending, equal values
// in arrival order. A beat is taken when start is high and busy is low; the
// beat flagged item_last closes the list. The sorted list then leaves on
// result/result_valid, one value per cycle on consecutive cycles, the final
// value flagged sorted_last. The receiver cannot stall: every result is shown
// for exactly one cycle. Up to MAX_ITEMS (64) values are held; further values
// of the same list are dropped and every result of that list has dropped_any
// set.
// The insertion row places one value per cycle while it is not shifting a list
// out; a list gives as many results as values were held, at most MAX_ITEMS.
// While the row is shifting out, the front end still takes beats into a
// two-beat queue, then raises busy until the row is free again. When the
// queue is empty, results start once the last beat has passed the queue and
// been inserted into the row.
`default_nettype none

module insertion_sorter
    import isort_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire item_t item,
    output logic       busy,
    output logic       result_valid,
    output result_t    result
);

    logic    push;
    qentry_t push_data;
    logic    queue_full;
    logic    q_valid;
    qentry_t q_head;
    logic    pop;

    // Front: counts the list's fill and marks beats to insert, drop or close
    isort_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .item       (item),
        .queue_full (queue_full),
        .busy       (busy),
        .push       (push),
        .push_data  (push_data)
    );

    // Queue: decouples intake from the row while it shifts a list out
    isort_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (q_valid),
        .head      (q_head)
    );

    // Back: every cell compares and shifts at once; shifts toward cell 0 to emit
    isort_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule : insertion_sorter

`default_nettype wire

### sv/isort_checker.sv
// Port-level checks on the insertion sorter output stream, bound to the top level.
`default_nettype none

module isort_checker
    import isort_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    result_valid,
    input wire result_t result
);

    // A list leaves without gaps up to its final value
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.sorted_last |=> result_valid)
        else $error("gap inside sorted list output");

    // The final value is followed by a quiet cycle
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.sorted_last |=> !result_valid)
        else $error("result straight after final value");

    // Values come out in ascending order within a list
    a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.sorted_last |=>
            ($signed(result.sorted_value) >= $signed($past(result.sorted_value))))
        else $error("sorted output not ascending");

    // The overflow note is the same on every value of a list
    a_drop_steady: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.sorted_last |=>
            (result.dropped_any == $past(result.dropped_any)))
        else $error("dropped_any changed within a list");

endmodule : isort_checker

bind insertion_sorter isort_checker u_isort_checker (.*);

`default_nettype wire
